// File: design/lfbr_pkg.sv
// ----------------------------------------------------------------------------
// lfbr_pkg: shared definitions for the lagged Fibonacci block generator
// Sizes, tap offsets, hash constants, command codes, controller states,
// datapath operations and the status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lfbr_pkg;

  // Generator shape
  localparam int unsigned FRAME_WORDS   = 32;
  localparam int unsigned HISTORY_WORDS = 64;
  localparam int unsigned TAP_A         = 37;
  localparam int unsigned TAP_B         = 45;
  localparam int unsigned TAP_C         = 53;

  // Seeding
  localparam logic [31:0] HASH_START    = 32'heebd22e1;
  localparam logic [8:0]  HASH_MUL      = 9'h16f;
  localparam int unsigned WARMUP_FACTOR = 20;

  // Derived sizes
  localparam int unsigned HAW         = $clog2(HISTORY_WORDS);
  localparam int unsigned FAW         = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int unsigned COPY_WORDS  = (FRAME_WORDS < HISTORY_WORDS) ? FRAME_WORDS
                                                                      : HISTORY_WORDS;
  localparam int unsigned CLR_WORDS   = (FRAME_WORDS > HISTORY_WORDS) ? FRAME_WORDS
                                                                      : HISTORY_WORDS;
  localparam int unsigned CLRW        = $clog2(CLR_WORDS);
  localparam int unsigned CPW         = $clog2(COPY_WORDS + 1);
  localparam int unsigned RPW         = $clog2(FRAME_WORDS + 1);
  localparam int unsigned SCW         = $clog2(HISTORY_WORDS + 1);
  localparam int unsigned WARM_DRAWS  = WARMUP_FACTOR * HISTORY_WORDS;
  localparam int unsigned WMW         = $clog2(WARM_DRAWS + 1);

  // Ring base moves back by this much on each refresh
  localparam int unsigned FRAME_STEP  = FRAME_WORDS % HISTORY_WORDS;

  // Tap offsets relative to the logical position of new word 0, mod history
  localparam int OFF_A = ((int'(TAP_A) - int'(FRAME_WORDS)) % int'(HISTORY_WORDS)
                          + int'(HISTORY_WORDS)) % int'(HISTORY_WORDS);
  localparam int OFF_B = ((int'(TAP_B) - int'(FRAME_WORDS)) % int'(HISTORY_WORDS)
                          + int'(HISTORY_WORDS)) % int'(HISTORY_WORDS);
  localparam int OFF_C = ((int'(TAP_C) - int'(FRAME_WORDS)) % int'(HISTORY_WORDS)
                          + int'(HISTORY_WORDS)) % int'(HISTORY_WORDS);
  localparam int OFF_D = ((int'(HISTORY_WORDS) - int'(FRAME_WORDS)) % int'(HISTORY_WORDS)
                          + int'(HISTORY_WORDS)) % int'(HISTORY_WORDS);

  // Input command codes
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED,
    ST_WARM,
    ST_BASE,
    ST_COPY,
    ST_CALC_INIT,
    ST_CALC,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_SEED_STORE,
    OP_SEED_INIT,
    OP_SEED_STEP,
    OP_WARM_STEP,
    OP_BASE,
    OP_COPY,
    OP_CALC_INIT,
    OP_CALC,
    OP_DRAW_RD,
    OP_OUT_LOAD
  } op_e;

  typedef struct packed {
    logic clear_done;
    logic seed_done;
    logic copy_done;
    logic calc_done;
    logic rp_zero;
    logic warm_zero;
    logic out_free;
    logic out_valid;
  } sts_t;

endpackage

`default_nettype wire

// File: design/lfbr_in_if.sv
// ----------------------------------------------------------------------------
// lfbr_in_if: command channel
// Valid/ready channel carrying draw and seed commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfbr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] seed_byte;
  logic       seed_last;

  modport source (output valid, output cmd, output seed_byte, output seed_last,
                  input ready);
  modport sink   (input valid, input cmd, input seed_byte, input seed_last,
                  output ready);
endinterface

`default_nettype wire

// File: design/lfbr_out_if.sv
// ----------------------------------------------------------------------------
// lfbr_out_if: result channel
// Valid/ready channel carrying random words.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfbr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

// File: design/lagged_fibonacci_block_rng_top.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_block_rng_top: four-tap additive lagged Fibonacci generator
// Hands out 32-bit words frame by frame, reseeds from a byte string.
// ----------------------------------------------------------------------------
// Draw: a command on an unread frame reads the frame RAM, and the word moves
//   on into the output register once that register is free. An empty frame
//   first costs a refresh: one base step, the copy of the old frame into the
//   history, then for each new word four single-port history reads and the
//   frame write.
// Seed byte: completes in its transfer cycle. Last byte: the string is hashed
//   into all HISTORY words, then 20*HISTORY draws are discarded, with one
//   refresh per frame.
// Reset: async active low; a clearing pass over max(HISTORY,FRAME) = 64 addresses
//   zeroes the history and frame RAMs before the first command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lagged_fibonacci_block_rng_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lfbr_in_if.sink     in_i,
  lfbr_out_if.source  out_o
);

  // Controller issues one datapath operation per cycle and watches status.
  lfbr_pkg::op_e  op;
  lfbr_pkg::sts_t sts;

  // Commands are taken only while the controller sits idle; a seed byte
  // completes in its transfer cycle, a draw continues into read and load.
  lfbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_last_i  (in_i.seed_last),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .op_o       (op)
  );

  // History is a ring: a refresh moves its base back by one frame, copies
  // the old frame into the newest slots, then builds the new frame from
  // four tap reads per word. The output register decouples the result
  // transfer so the next command can be taken while a word waits.
  lfbr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .seed_byte_i (in_i.seed_byte),
    .out_ready_i (out_o.ready),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_word_o  (out_o.random_word)
  );

endmodule

`default_nettype wire

// File: design/lfbr_ram.sv
// ----------------------------------------------------------------------------
// lfbr_ram: generic single-port RAM
// One access per cycle at a single address (write, read or both), registered read data held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic                 re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  output      logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/lfbr_ctrl.sv
// ----------------------------------------------------------------------------
// lfbr_ctrl: sequencing state machine
// Decodes commands and steps the datapath through clear, seed, warm-up,
// frame refresh and draw phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_cmd_i,
  input  wire logic          in_last_i,
  input  wire lfbr_pkg::sts_t sts_i,
  output      logic          in_ready_o,
  output      lfbr_pkg::op_e op_o
);

  lfbr_pkg::state_e state_q, state_d;
  logic             ret_warm_q, ret_warm_d;   // refresh called from warm-up

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lfbr_pkg::ST_CLEAR;
      ret_warm_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_warm_q <= ret_warm_d;
    end
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    ret_warm_d = ret_warm_q;
    unique case (state_q)
      lfbr_pkg::ST_CLEAR: begin
        if (sts_i.clear_done) state_d = lfbr_pkg::ST_IDLE;
      end
      lfbr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == lfbr_pkg::CMD_DRAW) begin
            if (sts_i.rp_zero) begin
              ret_warm_d = 1'b0;
              state_d    = lfbr_pkg::ST_BASE;
            end else begin
              state_d = lfbr_pkg::ST_DRAW_RD;
            end
          end else if (in_last_i) begin
            state_d = lfbr_pkg::ST_SEED_INIT;
          end
        end
      end
      lfbr_pkg::ST_SEED_INIT: state_d = lfbr_pkg::ST_SEED;
      lfbr_pkg::ST_SEED: begin
        if (sts_i.seed_done) state_d = lfbr_pkg::ST_WARM;
      end
      lfbr_pkg::ST_WARM: begin
        if (sts_i.warm_zero) begin
          state_d = lfbr_pkg::ST_IDLE;
        end else if (sts_i.rp_zero) begin
          ret_warm_d = 1'b1;
          state_d    = lfbr_pkg::ST_BASE;
        end
      end
      lfbr_pkg::ST_BASE: state_d = lfbr_pkg::ST_COPY;
      lfbr_pkg::ST_COPY: begin
        if (sts_i.copy_done) state_d = lfbr_pkg::ST_CALC_INIT;
      end
      lfbr_pkg::ST_CALC_INIT: state_d = lfbr_pkg::ST_CALC;
      lfbr_pkg::ST_CALC: begin
        if (sts_i.calc_done) begin
          state_d = ret_warm_q ? lfbr_pkg::ST_WARM : lfbr_pkg::ST_DRAW_RD;
        end
      end
      lfbr_pkg::ST_DRAW_RD: state_d = lfbr_pkg::ST_DRAW_OUT;
      lfbr_pkg::ST_DRAW_OUT: begin
        if (sts_i.out_free) state_d = lfbr_pkg::ST_IDLE;
      end
      default: state_d = lfbr_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    op_o       = lfbr_pkg::OP_NONE;
    unique case (state_q)
      lfbr_pkg::ST_CLEAR: op_o = lfbr_pkg::OP_CLEAR;
      lfbr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (in_cmd_i == lfbr_pkg::CMD_SEED)) op_o = lfbr_pkg::OP_SEED_STORE;
      end
      lfbr_pkg::ST_SEED_INIT: op_o = lfbr_pkg::OP_SEED_INIT;
      lfbr_pkg::ST_SEED:      op_o = lfbr_pkg::OP_SEED_STEP;
      lfbr_pkg::ST_WARM: begin
        if (!sts_i.warm_zero && !sts_i.rp_zero) op_o = lfbr_pkg::OP_WARM_STEP;
      end
      lfbr_pkg::ST_BASE:      op_o = lfbr_pkg::OP_BASE;
      lfbr_pkg::ST_COPY:      op_o = lfbr_pkg::OP_COPY;
      lfbr_pkg::ST_CALC_INIT: op_o = lfbr_pkg::OP_CALC_INIT;
      lfbr_pkg::ST_CALC:      op_o = lfbr_pkg::OP_CALC;
      lfbr_pkg::ST_DRAW_RD:   op_o = lfbr_pkg::OP_DRAW_RD;
      lfbr_pkg::ST_DRAW_OUT: begin
        if (sts_i.out_free) op_o = lfbr_pkg::OP_OUT_LOAD;
      end
      default: op_o = lfbr_pkg::OP_NONE;
    endcase
  end

  // A draw read always finds an unread word
  a_draw_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lfbr_pkg::ST_DRAW_RD) |-> !sts_i.rp_zero)
    else $error("draw read with empty frame");

  // A finished refresh leaves a full frame
  a_refresh_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lfbr_pkg::ST_CALC) && sts_i.calc_done) |=> !sts_i.rp_zero)
    else $error("refresh left frame empty");

  // Loading the output register always presents a word next cycle
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lfbr_pkg::ST_DRAW_OUT) && sts_i.out_free) |=> sts_i.out_valid)
    else $error("result lost at output register");

endmodule

`default_nettype wire

// File: design/lfbr_dp.sv
// ----------------------------------------------------------------------------
// lfbr_dp: generator datapath
// History ring, frame and seed RAMs, address counters, tap adder, hash
// and output register, driven one operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbr_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lfbr_pkg::op_e  op_i,
  input  wire logic [7:0]     seed_byte_i,
  input  wire logic           out_ready_i,
  output      lfbr_pkg::sts_t sts_o,
  output      logic           out_valid_o,
  output      logic [31:0]    out_word_o
);

  localparam int unsigned H    = lfbr_pkg::HISTORY_WORDS;
  localparam int unsigned F    = lfbr_pkg::FRAME_WORDS;
  localparam int unsigned HAW  = lfbr_pkg::HAW;
  localparam int unsigned FAW  = lfbr_pkg::FAW;
  localparam int unsigned CLRW = lfbr_pkg::CLRW;
  localparam int unsigned CPW  = lfbr_pkg::CPW;
  localparam int unsigned RPW  = lfbr_pkg::RPW;
  localparam int unsigned SCW  = lfbr_pkg::SCW;
  localparam int unsigned WMW  = lfbr_pkg::WMW;

  localparam logic [HAW:0] H_LIM      = (HAW+1)'(H);
  localparam logic [2:0]   K_FIRST    = 3'd1;   // first tap data returns
  localparam logic [2:0]   K_SUM      = 3'd4;   // last tap data, word written

  function automatic logic [HAW-1:0] wrap_inc(input logic [HAW-1:0] x);
    return (x == HAW'(H - 1)) ? '0 : x + 1'b1;
  endfunction

  logic [HAW-1:0]  base_q, base_d;   // physical slot of logical index 0
  logic [HAW-1:0]  wp_q, wp_d;       // copy write pointer
  logic [HAW-1:0]  q_q, q_d;         // physical slot of logical word i
  logic [CLRW-1:0] clr_q, clr_d;
  logic [CPW-1:0]  c_q, c_d;
  logic [FAW-1:0]  i_q, i_d;
  logic [2:0]      k_q, k_d;
  logic [RPW-1:0]  rp_q, rp_d;
  logic [WMW-1:0]  warm_q, warm_d;
  logic [SCW-1:0]  cnt_q, cnt_d;
  logic [SCW-1:0]  n_q, n_d;
  logic [HAW-1:0]  j_q, j_d;         // seed byte index, wraps at n
  logic [HAW-1:0]  si_q, si_d;       // history word being seeded
  logic            out_valid_q, out_valid_d;
  logic [31:0]     h_q, h_d;
  logic [31:0]     acc_q, acc_d;
  logic [31:0]     out_word_q, out_word_d;

  logic            hist_we, hist_re;
  logic [HAW-1:0]  hist_addr;
  logic [31:0]     hist_wdata, hist_rdata;
  logic            frame_we, frame_re;
  logic [FAW-1:0]  frame_addr;
  logic [31:0]     frame_wdata, frame_rdata;
  logic            seed_we, seed_re;
  logic [HAW-1:0]  seed_addr;
  logic [7:0]      seed_rdata;

  logic [HAW-1:0]  tap_off;
  logic [HAW:0]    tap_sum;
  logic [HAW-1:0]  tap_addr;
  logic [HAW-1:0]  base_new;
  logic [SCW-1:0]  j_inc;
  logic [HAW-1:0]  j_next;

  always_comb begin
    case (k_q)
      3'd0:    tap_off = HAW'(lfbr_pkg::OFF_A);
      3'd1:    tap_off = HAW'(lfbr_pkg::OFF_B);
      3'd2:    tap_off = HAW'(lfbr_pkg::OFF_C);
      default: tap_off = HAW'(lfbr_pkg::OFF_D);
    endcase
  end

  assign tap_sum  = {1'b0, q_q} + {1'b0, tap_off};
  assign tap_addr = (tap_sum >= H_LIM) ? HAW'(tap_sum - H_LIM) : HAW'(tap_sum);

  assign base_new = (base_q >= HAW'(lfbr_pkg::FRAME_STEP))
                  ? base_q - HAW'(lfbr_pkg::FRAME_STEP)
                  : base_q + HAW'(H - lfbr_pkg::FRAME_STEP);

  assign j_inc  = SCW'(j_q) + SCW'(1);
  assign j_next = (j_inc == n_q) ? '0 : HAW'(j_inc);

  always_comb begin
    base_d      = base_q;
    wp_d        = wp_q;
    q_d         = q_q;
    clr_d       = clr_q;
    c_d         = c_q;
    i_d         = i_q;
    k_d         = k_q;
    rp_d        = rp_q;
    warm_d      = warm_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    j_d         = j_q;
    si_d        = si_q;
    h_d         = h_q;
    acc_d       = acc_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    hist_we     = 1'b0;
    hist_re     = 1'b0;
    hist_addr   = '0;
    hist_wdata  = '0;
    frame_we    = 1'b0;
    frame_re    = 1'b0;
    frame_addr  = '0;
    frame_wdata = '0;
    seed_we     = 1'b0;
    seed_re     = 1'b0;
    seed_addr   = '0;
    unique case (op_i)
      lfbr_pkg::OP_NONE: begin
      end
      lfbr_pkg::OP_CLEAR: begin
        hist_we    = (int'(clr_q) < int'(H));
        hist_addr  = HAW'(clr_q);
        frame_we   = (int'(clr_q) < int'(F));
        frame_addr = FAW'(clr_q);
        clr_d      = clr_q + 1'b1;
      end
      lfbr_pkg::OP_SEED_STORE: begin
        if (cnt_q != SCW'(H)) begin
          seed_we   = 1'b1;
          seed_addr = HAW'(cnt_q);
          cnt_d     = cnt_q + 1'b1;
        end
      end
      lfbr_pkg::OP_SEED_INIT: begin
        base_d  = '0;
        n_d     = cnt_q;
        cnt_d   = '0;
        h_d     = lfbr_pkg::HASH_START;
        si_d    = '0;
        j_d     = '0;
        seed_re = 1'b1;
        rp_d    = '0;
        warm_d  = WMW'(lfbr_pkg::WARM_DRAWS);
      end
      lfbr_pkg::OP_SEED_STEP: begin
        hist_we    = 1'b1;
        hist_addr  = si_q;
        hist_wdata = h_q;
        h_d        = h_q * lfbr_pkg::HASH_MUL + 32'(seed_rdata);
        seed_re    = 1'b1;
        seed_addr  = j_next;
        j_d        = j_next;
        si_d       = si_q + 1'b1;
      end
      lfbr_pkg::OP_WARM_STEP: begin
        rp_d   = rp_q - 1'b1;
        warm_d = warm_q - 1'b1;
      end
      lfbr_pkg::OP_BASE: begin
        base_d = base_new;
        wp_d   = base_new;
        c_d    = '0;
      end
      lfbr_pkg::OP_COPY: begin
        if (c_q != CPW'(lfbr_pkg::COPY_WORDS)) begin
          frame_re   = 1'b1;
          frame_addr = FAW'(c_q);
        end
        if (c_q != '0) begin
          hist_we    = 1'b1;
          hist_addr  = wp_q;
          hist_wdata = frame_rdata;
          wp_d       = wrap_inc(wp_q);
        end
        c_d = c_q + 1'b1;
      end
      lfbr_pkg::OP_CALC_INIT: begin
        q_d = base_q;
        i_d = '0;
        k_d = '0;
      end
      lfbr_pkg::OP_CALC: begin
        if (k_q != K_SUM) begin
          hist_re   = 1'b1;
          hist_addr = tap_addr;
        end
        if (k_q == K_FIRST) begin
          acc_d = hist_rdata;
        end else if (k_q != 3'd0) begin
          acc_d = acc_q + hist_rdata;
        end
        if (k_q == K_SUM) begin
          frame_we    = 1'b1;
          frame_addr  = i_q;
          frame_wdata = acc_q + hist_rdata;
          k_d         = '0;
          i_d         = i_q + 1'b1;
          q_d         = wrap_inc(q_q);
          if (i_q == FAW'(F - 1)) rp_d = RPW'(F);
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      lfbr_pkg::OP_DRAW_RD: begin
        frame_re   = 1'b1;
        frame_addr = FAW'(rp_q - 1'b1);
        rp_d       = rp_q - 1'b1;
      end
      lfbr_pkg::OP_OUT_LOAD: begin
        out_word_d  = frame_rdata;
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      wp_q        <= '0;
      q_q         <= '0;
      clr_q       <= '0;
      c_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      rp_q        <= '0;
      warm_q      <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      j_q         <= '0;
      si_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      wp_q        <= wp_d;
      q_q         <= q_d;
      clr_q       <= clr_d;
      c_q         <= c_d;
      i_q         <= i_d;
      k_q         <= k_d;
      rp_q        <= rp_d;
      warm_q      <= warm_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      j_q         <= j_d;
      si_q        <= si_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q        <= h_d;
    acc_q      <= acc_d;
    out_word_q <= out_word_d;
  end

  lfbr_ram #(.WIDTH(32), .DEPTH(H)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .re_i    (hist_re),
    .addr_i  (hist_addr),
    .wdata_i (hist_wdata),
    .rdata_o (hist_rdata)
  );

  lfbr_ram #(.WIDTH(32), .DEPTH(F)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .re_i    (frame_re),
    .addr_i  (frame_addr),
    .wdata_i (frame_wdata),
    .rdata_o (frame_rdata)
  );

  lfbr_ram #(.WIDTH(8), .DEPTH(H)) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (seed_we),
    .re_i    (seed_re),
    .addr_i  (seed_addr),
    .wdata_i (seed_byte_i),
    .rdata_o (seed_rdata)
  );

  assign sts_o.clear_done = (clr_q == CLRW'(lfbr_pkg::CLR_WORDS - 1));
  assign sts_o.seed_done  = (si_q == HAW'(H - 1));
  assign sts_o.copy_done  = (c_q == CPW'(lfbr_pkg::COPY_WORDS));
  assign sts_o.calc_done  = (k_q == K_SUM) && (i_q == FAW'(F - 1));
  assign sts_o.rp_zero    = (rp_q == '0);
  assign sts_o.warm_zero  = (warm_q == '0);
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;
  assign sts_o.out_valid  = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// File: tb/lagged_fibonacci_block_rng_top_tb.sv
// ----------------------------------------------------------------------------
// lagged_fibonacci_block_rng_top_tb: self-checking bench for the LFG block
// Draw and seed commands go in through a queue-fed driver. An in-bench copy
// of the four-tap generator predicts every random word, and a monitor checks
// each output transfer in order. Both channels idle at random.
// ----------------------------------------------------------------------------

module lagged_fibonacci_block_rng_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generator shape, as signed ints for index math
  localparam int FW = int'(lfbr_pkg::FRAME_WORDS);
  localparam int HW = int'(lfbr_pkg::HISTORY_WORDS);
  localparam int TA = int'(lfbr_pkg::TAP_A);
  localparam int TB = int'(lfbr_pkg::TAP_B);
  localparam int TC = int'(lfbr_pkg::TAP_C);

  // Random part stops here; the calm tail comes on top
  localparam int ITEM_TARGET = 480;
  // Tail of the run with no idling on either side
  localparam int CALM_ITEMS  = 60;
  // Longest silent stretch is a reseed: hashing, 1280 warm-up draws and
  // 40 frame refreshes. Keep the limit well above that.
  localparam int IDLE_LIMIT  = 40000;
  // Settle time once all words are in
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic       cmd;
    logic [7:0] seed_byte;
    logic       seed_last;
  } lfg_cmd_t;

  logic clk_i;
  logic rst_ni;

  lfbr_in_if  cmd_if ();
  lfbr_out_if word_if ();

  lagged_fibonacci_block_rng_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (word_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Generator shadow state
  // --------------------------------------------------------------------------
  logic [31:0] lag_hist   [HW];  // index 0 is the newest word
  logic [31:0] lag_frame  [FW];
  int unsigned frame_left;       // unread words in lag_frame
  logic [7:0]  seed_mem   [HW];
  int unsigned seed_len;

  lfg_cmd_t    pending_cmds[$];
  logic [31:0] expected_words[$];

  int  mismatches;
  int  idle_cycles;
  int  cmd_gap;
  int  stall_left;
  bit  cmd_taken;

  function automatic int wrap_hist(int k);
    int m;
    m = k % HW;
    if (m < 0) m += HW;
    return m;
  endfunction

  // History moves back one frame, old frame becomes the newest words, then
  // each new word sums the three taps and the oldest lag.
  function automatic void lfg_refill();
    int i;
    int base;
    for (i = HW - 1; i >= FW; i--) lag_hist[i] = lag_hist[i - FW];
    for (i = 0; i < FW && i < HW; i++) lag_hist[i] = lag_frame[i];
    for (i = 0; i < FW; i++) begin
      base = i - FW;
      lag_frame[i] = lag_hist[wrap_hist(base + TA)] + lag_hist[wrap_hist(base + TB)]
                   + lag_hist[wrap_hist(base + TC)] + lag_hist[wrap_hist(base + HW)];
    end
    frame_left = lfbr_pkg::FRAME_WORDS;
  endfunction

  function automatic logic [31:0] lfg_next_word();
    if (frame_left == 0 || frame_left > lfbr_pkg::FRAME_WORDS) lfg_refill();
    frame_left--;
    return lag_frame[frame_left];
  endfunction

  // Hash the stored bytes into the history, cycling over them, then warm up
  function automatic void lfg_reseed();
    logic [31:0] h;
    int unsigned n;
    int i;
    h = lfbr_pkg::HASH_START;
    n = (seed_len == 0) ? 1 : seed_len;
    for (i = 0; i < HW; i++) begin
      lag_hist[i] = h;
      h = h * 32'(lfbr_pkg::HASH_MUL) + 32'(seed_mem[i % n]);
    end
    frame_left = 0;
    seed_len   = 0;
    for (i = 0; i < int'(lfbr_pkg::WARMUP_FACTOR) * HW; i++) void'(lfg_next_word());
  endfunction

  function automatic void lfg_accept(lfg_cmd_t c);
    if (c.cmd == lfbr_pkg::CMD_DRAW) begin
      expected_words.push_back(lfg_next_word());
    end else begin
      // bytes past a full store are dropped, but a last flag still counts
      if (seed_len < lfbr_pkg::HISTORY_WORDS) begin
        seed_mem[seed_len] = c.seed_byte;
        seed_len++;
      end
      if (c.seed_last) lfg_reseed();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic push_cmd(logic cmd, logic [7:0] b, logic last);
    lfg_cmd_t c;
    c.cmd       = cmd;
    c.seed_byte = b;
    c.seed_last = last;
    pending_cmds.push_back(c);
  endtask

  // Draws carry junk in the seed fields; the block must ignore it
  task automatic add_draws(int n);
    for (int k = 0; k < n; k++)
      push_cmd(lfbr_pkg::CMD_DRAW, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic add_seed(int len, bit terminated);
    for (int k = 0; k < len; k++)
      push_cmd(lfbr_pkg::CMD_SEED, 8'($urandom_range(0, 255)),
               terminated && (k == len - 1));
  endtask

  // --------------------------------------------------------------------------
  // Command driver: changes at the falling edge, valid held until transfer
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_cmds
    logic     nxt_valid;
    lfg_cmd_t c;
    if (rst_ni) begin
      nxt_valid = cmd_if.valid;
      if (cmd_taken) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (cmd_gap > 0) begin
          cmd_gap--;
        end else if (pending_cmds.size() > 0) begin
          if (pending_cmds.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0) begin
            // idle burst, counting this cycle
            cmd_gap = $urandom_range(1, 12) - 1;
          end else begin
            c = pending_cmds.pop_front();
            cmd_if.cmd       <= c.cmd;
            cmd_if.seed_byte <= c.seed_byte;
            cmd_if.seed_last <= c.seed_last;
            nxt_valid = 1'b1;
          end
        end
      end
      cmd_if.valid <= nxt_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Result back-pressure: random stall bursts, none in the tail
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (stall_left == 0 && pending_cmds.size() >= CALM_ITEMS &&
          $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 12);
      if (stall_left > 0) begin
        stall_left--;
        word_if.ready <= 1'b0;
      end else begin
        word_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on command transfers, check on word transfers, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    logic     out_fire;
    logic     [31:0] want;
    lfg_cmd_t c;
    cmd_taken = rst_ni && cmd_if.valid && cmd_if.ready;
    out_fire  = rst_ni && word_if.valid && word_if.ready;
    if (cmd_taken) begin
      c.cmd       = cmd_if.cmd;
      c.seed_byte = cmd_if.seed_byte;
      c.seed_last = cmd_if.seed_last;
      lfg_accept(c);
    end
    if (out_fire) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected random_word transfer: expected none, actual %08h",
                 $time, word_if.random_word);
      end else begin
        want = expected_words.pop_front();
        if (word_if.random_word !== want) begin
          mismatches++;
          $display("%0t: random_word mismatch: expected %08h, actual %08h",
                   $time, want, word_if.random_word);
        end
      end
    end
    // watchdog: cycles without any transfer on either channel
    if (cmd_taken || out_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("lagged_fibonacci_block_rng_top_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int r;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.cmd        = lfbr_pkg::CMD_DRAW;
    cmd_if.seed_byte  = 8'h00;
    cmd_if.seed_last  = 1'b0;
    word_if.ready     = 1'b0;
    mismatches        = 0;
    idle_cycles       = 0;
    cmd_gap           = 0;
    stall_left        = 0;
    cmd_taken         = 1'b0;

    // shadow state after reset
    foreach (lag_hist[i])  lag_hist[i]  = '0;
    foreach (lag_frame[i]) lag_frame[i] = '0;
    foreach (seed_mem[i])  seed_mem[i]  = '0;
    frame_left = 0;
    seed_len   = 0;

    // Directed: draws from the all-zero history, a one-byte seed (hash
    // cycles over a single byte), a multi-byte seed, draws with junk seed
    // fields, then a two-byte seed of the byte extremes.
    add_draws(3);
    push_cmd(lfbr_pkg::CMD_SEED, 8'h00, 1'b1);
    add_draws(2);
    push_cmd(lfbr_pkg::CMD_SEED, 8'hff, 1'b0);
    push_cmd(lfbr_pkg::CMD_SEED, 8'ha5, 1'b0);
    push_cmd(lfbr_pkg::CMD_SEED, 8'h5a, 1'b0);
    push_cmd(lfbr_pkg::CMD_SEED, 8'h7f, 1'b1);
    push_cmd(lfbr_pkg::CMD_DRAW, 8'hff, 1'b1);
    push_cmd(lfbr_pkg::CMD_DRAW, 8'h00, 1'b1);
    push_cmd(lfbr_pkg::CMD_SEED, 8'h00, 1'b0);
    push_cmd(lfbr_pkg::CMD_SEED, 8'hff, 1'b1);
    add_draws(2);

    // Overlong seed: store fills at 64 bytes, last flag lands past it
    add_seed($urandom_range(HW + 1, HW + 8), 1'b1);
    add_draws($urandom_range(8, 40));

    // Random part: mostly draw runs (crossing frame boundaries) and
    // well-formed seed strings, some unterminated bytes and long strings.
    while (pending_cmds.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        add_draws($urandom_range(1, 48));
      end else if (r < 88) begin
        add_seed($urandom_range(1, 8), 1'b1);
        add_draws($urandom_range(1, 40));
      end else if (r < 94) begin
        // stray bytes, folded into whatever string follows
        add_seed($urandom_range(1, 3), 1'b0);
      end else begin
        add_seed($urandom_range(HW - 4, HW + 8), 1'b1);
        add_draws($urandom_range(1, 40));
      end
    end
    // tail of draws so every reseed gets checked, with no idling
    add_draws(CALM_ITEMS);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || cmd_if.valid) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("lagged_fibonacci_block_rng_top_tb: PASS");
    end else begin
      $display("lagged_fibonacci_block_rng_top_tb: FAIL");
    end
    $finish;
  end

endmodule
